[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and codes for the bitmap page allocator
// Request and result payloads, status and mode codes, controller states.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ADDR_W    = 48;
  localparam int COUNT_W   = 17;
  // The limit register is 17 bits, so any managed page number fits 17 bits
  localparam int PAGE_W    = 17;
  localparam int LIMIT_MAX = 131071;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 17'd65536;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SPACE    = 2'd1;
  localparam logic [1:0] ST_IGNORED     = 2'd2;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  page_address;
    logic [COUNT_W-1:0] free_count;
  } out_res_t;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    ALLOC,
    FREE_DIV1,
    FREE_DIV2,
    FREE_CHK
  } state_t;

endpackage

[sv/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator: single-page bitmap frame allocator
// Used-page bitmap in RAM, allocation by word scan, free by read-modify-write.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on in_req while busy is low; the transfer
//   happens on that edge. mode MODE_ALLOC takes the lowest free page below
//   the page limit, MODE_FREE releases the page holding in_req.address.
//   Each request yields one result on out_res, shown for exactly one cycle
//   with out_valid high; the receiver cannot stall it. The next request may
//   start in the cycle that shows the result.
//   An allocation scans the bitmap from word zero, one RAM word read per
//   cycle, and stops at the first word with a free page below the limit or
//   at the last word below it; a free runs through split, read and write
//   back, or ends in the split step when the address is ignored.
//   cfg_data sets the page limit through cfg_valid/cfg_ready (always ready);
//   write it only while the block is idle.
//   After reset, busy stays high while the MAP_WORDS bitmap RAM words (1024
//   by default) are cleared one word per cycle; the count is zero
//   and the limit returns to 65536.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int PAGE_COUNT    = 65536,
  parameter int PAGE_SHIFT    = 12,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  bpa_pkg::in_req_t            in_req,
  output logic                        out_valid,
  output bpa_pkg::out_res_t           out_res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bpa_pkg::COUNT_W-1:0] cfg_data
);

  localparam int W         = MAP_WORD_BITS;
  localparam int MAP_WORDS = (PAGE_COUNT + W - 1) / W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(W);
  localparam int CW        = bpa_pkg::COUNT_W;
  localparam int LIM_CAP_I = (PAGE_COUNT < bpa_pkg::LIMIT_MAX) ? PAGE_COUNT
                                                                : bpa_pkg::LIMIT_MAX;
  localparam logic [CW-1:0] LIM_CAP  = CW'(LIM_CAP_I);
  localparam logic [CW-1:0] WSTEP    = CW'(W);
  localparam logic [AW-1:0] LAST_WRD = AW'(MAP_WORDS - 1);

  bpa_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CW-1:0]     limit_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [bpa_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [AW-1:0]     word_r, word_nxt;
  logic [CW-1:0]     base_r, base_nxt;
  logic [W-1:0]      mask_r, mask_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  bpa_pkg::out_res_t out_res_r, out_res_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [W-1:0]      ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [W-1:0]      ram_rdata;

  logic [CW-1:0]     lim;
  logic              accept;
  logic [W-1:0]      free_bits;
  logic              found;
  logic [BW-1:0]     ffs_idx;
  logic [AW-1:0]     word_adv;
  logic [CW-1:0]     base_adv;
  logic              scan_end;
  logic [bpa_pkg::ADDR_W-1:0] pnum;
  logic              free_bad;
  logic [bpa_pkg::PAGE_W-1:0] free_page;
  logic [AW-1:0]     split_word;
  logic [BW-1:0]     split_bit;
  logic [CW-1:0]     alloc_page;

  function automatic logic [W-1:0] tail_mask(input logic [CW-1:0] lim_v,
                                             input logic [CW-1:0] base_v);
    logic [W-1:0]  m;
    logic [CW-1:0] rem;
    rem = (base_v < lim_v) ? (lim_v - base_v) : '0;
    for (int b = 0; b < W; b++) begin
      m[b] = rem > CW'(b);
    end
    return m;
  endfunction

  function automatic logic [CW-1:0] free_of(input logic [CW-1:0] lim_v,
                                            input logic [CW-1:0] cnt_v);
    return (cnt_v < lim_v) ? (lim_v - cnt_v) : '0;
  endfunction

  assign lim       = (limit_r < LIM_CAP) ? limit_r : LIM_CAP;
  assign busy      = (state_r != bpa_pkg::IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // allocation scan on the word that just came out of the RAM
  assign free_bits = ~ram_rdata & mask_r;
  assign found     = |free_bits;
  assign word_adv  = word_r + AW'(1);
  assign base_adv  = base_r + WSTEP;
  // compare one bit wider so the base of the last word cannot wrap
  assign scan_end  = ({1'b0, base_r} + {1'b0, WSTEP}) >= {1'b0, lim};

  always_comb begin
    ffs_idx = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        ffs_idx = BW'(b);
      end
    end
  end

  assign alloc_page = base_r + CW'(ffs_idx);

  // free request: drop the offset, range check against the limit
  assign pnum      = addr_r >> PAGE_SHIFT;
  assign free_bad  = (addr_r == '0) || (pnum >= bpa_pkg::ADDR_W'(lim));
  assign free_page = pnum[bpa_pkg::PAGE_W-1:0];

  bpa_split #(
    .MAP_WORD_BITS (W),
    .AW            (AW),
    .BW            (BW)
  ) u_split (
    .clk    (clk),
    .page_i (free_page),
    .word_o (split_word),
    .bit_o  (split_bit)
  );

  bpa_ram #(
    .WIDTH (W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::CLEAR: begin
        if (clr_r == LAST_WRD) begin
          state_nxt = bpa_pkg::IDLE;
        end
      end
      bpa_pkg::IDLE: begin
        if (accept) begin
          state_nxt = (in_req.mode == bpa_pkg::MODE_ALLOC) ? bpa_pkg::ALLOC
                                                           : bpa_pkg::FREE_DIV1;
        end
      end
      bpa_pkg::ALLOC: begin
        if (found || scan_end) begin
          state_nxt = bpa_pkg::IDLE;
        end
      end
      bpa_pkg::FREE_DIV1: begin
        state_nxt = free_bad ? bpa_pkg::IDLE : bpa_pkg::FREE_DIV2;
      end
      bpa_pkg::FREE_DIV2: state_nxt = bpa_pkg::FREE_CHK;
      bpa_pkg::FREE_CHK:  state_nxt = bpa_pkg::IDLE;
      default:            state_nxt = bpa_pkg::IDLE;
    endcase
  end

  // datapath and RAM port control
  always_comb begin
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    mask_nxt      = mask_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    unique case (state_r)
      bpa_pkg::CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      bpa_pkg::IDLE: begin
        // word zero is read ahead so the scan sees it next cycle
        if (accept) begin
          addr_nxt = in_req.address;
          word_nxt = '0;
          base_nxt = '0;
          mask_nxt = tail_mask(lim, '0);
        end
      end
      bpa_pkg::ALLOC: begin
        ram_raddr = word_adv;
        if (found) begin
          ram_we                   = 1'b1;
          ram_wdata                = ram_rdata | (W'(1) << ffs_idx);
          count_nxt                = count_r + CW'(1);
          out_valid_nxt            = 1'b1;
          out_res_nxt.status       = bpa_pkg::ST_OK;
          out_res_nxt.page_address = bpa_pkg::ADDR_W'(alloc_page) << PAGE_SHIFT;
          out_res_nxt.free_count   = free_of(lim, count_r + CW'(1));
        end else if (scan_end) begin
          out_valid_nxt            = 1'b1;
          out_res_nxt.status       = bpa_pkg::ST_NO_SPACE;
          out_res_nxt.page_address = '0;
          out_res_nxt.free_count   = free_of(lim, count_r);
        end else begin
          word_nxt = word_adv;
          base_nxt = base_adv;
          mask_nxt = tail_mask(lim, base_adv);
        end
      end
      bpa_pkg::FREE_DIV1: begin
        if (free_bad) begin
          out_valid_nxt            = 1'b1;
          out_res_nxt.status       = bpa_pkg::ST_IGNORED;
          out_res_nxt.page_address = '0;
          out_res_nxt.free_count   = free_of(lim, count_r);
        end
      end
      bpa_pkg::FREE_DIV2: begin
        ram_raddr = split_word;
        word_nxt  = split_word;
        bit_nxt   = split_bit;
      end
      bpa_pkg::FREE_CHK: begin
        out_valid_nxt            = 1'b1;
        out_res_nxt.page_address = '0;
        if (!ram_rdata[bit_r]) begin
          out_res_nxt.status     = bpa_pkg::ST_DOUBLE_FREE;
          out_res_nxt.free_count = free_of(lim, count_r);
        end else begin
          ram_we                 = 1'b1;
          ram_wdata              = ram_rdata & ~(W'(1) << bit_r);
          count_nxt              = (count_r != '0) ? count_r - CW'(1) : count_r;
          out_res_nxt.status     = bpa_pkg::ST_OK;
          out_res_nxt.free_count = free_of(lim, count_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::CLEAR;
      clr_r       <= '0;
      limit_r     <= bpa_pkg::LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    word_r    <= word_nxt;
    base_r    <= base_nxt;
    mask_r    <= mask_nxt;
    bit_r     <= bit_nxt;
    out_res_r <= out_res_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != bpa_pkg::IDLE))
    else $error("accepted request did not start work");

  a_result_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != bpa_pkg::IDLE) && ($past(state_r) != bpa_pkg::CLEAR))
    else $error("result without a request in flight");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LIM_CAP)
    else $error("allocated count beyond managed pages");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == bpa_pkg::CLEAR || state_r == bpa_pkg::ALLOC ||
                state_r == bpa_pkg::FREE_CHK))
    else $error("bitmap write outside clear, allocate or free write-back");

endmodule

[sv/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bpa_split.sv]
// ----------------------------------------------------------------------------
// bpa_split: page number to bitmap word and bit position
// Two-step split by the word width: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
module bpa_split #(
  parameter int MAP_WORD_BITS = 64,
  parameter int AW            = 10,
  parameter int BW            = $clog2(MAP_WORD_BITS)
) (
  input  logic                       clk,
  input  logic [bpa_pkg::PAGE_W-1:0] page_i,
  output logic [AW-1:0]              word_o,
  output logic [BW-1:0]              bit_o
);

  localparam int RW = 31;
  localparam int PW = bpa_pkg::PAGE_W + RW;
  localparam int QW = PW - 32;
  // floor(2^32 / W) + 1 is exact for every 17-bit page and W from 3 up to 64
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << 32) / MAP_WORD_BITS + 1);
  localparam logic [bpa_pkg::PAGE_W-1:0] WBITS = bpa_pkg::PAGE_W'(MAP_WORD_BITS);

  logic [PW-1:0]              prod_r;
  logic [bpa_pkg::PAGE_W-1:0] page_r;
  logic [QW-1:0]              quot;
  logic [bpa_pkg::PAGE_W-1:0] rem;

  always_ff @(posedge clk) begin
    prod_r <= PW'(page_i) * PW'(RECIP);
    page_r <= page_i;
  end

  assign quot   = prod_r[PW-1:32];
  assign rem    = page_r - bpa_pkg::PAGE_W'(bpa_pkg::PAGE_W'(quot) * WBITS);
  assign word_o = AW'(quot);
  assign bit_o  = BW'(rem);

endmodule

[dv/tb_bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator: self-checking bench for the bitmap page allocator
// Drives allocate and free requests under a series of page limits. A
// scoreboard keeps its own used-page map and count, predicts each result,
// and compares every result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_COUNT  = 65536;
  localparam int PAGE_SHIFT  = 12;
  localparam int PHASE_ITEMS = 113;
  localparam int CYCLE_LIMIT = 4000000;

  class page_alloc_scoreboard;
    bit                 page_used [PAGE_COUNT];
    int unsigned        used_count;
    int unsigned        limit_reg;
    bpa_pkg::out_res_t  expected_q[$];
    int unsigned        held_pages[$];
    int                 errors;

    function void reset_state();
      foreach (page_used[i]) page_used[i] = 1'b0;
      used_count = 0;
      limit_reg  = bpa_pkg::LIMIT_RESET;
      expected_q.delete();
      held_pages.delete();
      errors     = 0;
    endfunction

    function int unsigned active_limit();
      return (limit_reg < PAGE_COUNT) ? limit_reg : PAGE_COUNT;
    endfunction

    // Predict the result of an accepted request and update the page map
    function void note_request(bpa_pkg::in_req_t req);
      int unsigned       lim;
      longint unsigned   req_page;
      bpa_pkg::out_res_t res;
      bit                found;
      lim        = active_limit();
      res        = '0;
      res.status = bpa_pkg::ST_OK;
      if (req.mode == bpa_pkg::MODE_ALLOC) begin
        found = 1'b0;
        for (int unsigned p = 0; p < lim && !found; p++) begin
          if (!page_used[p]) begin
            page_used[p] = 1'b1;
            used_count++;
            res.page_address = bpa_pkg::ADDR_W'(p) << PAGE_SHIFT;
            held_pages.push_back(p);
            found = 1'b1;
          end
        end
        if (!found) res.status = bpa_pkg::ST_NO_SPACE;
      end else begin
        req_page = longint'(req.address) >> PAGE_SHIFT;
        if (req.address == '0 || req_page >= lim) begin
          res.status = bpa_pkg::ST_IGNORED;
        end else if (!page_used[req_page]) begin
          res.status = bpa_pkg::ST_DOUBLE_FREE;
        end else begin
          page_used[req_page] = 1'b0;
          if (used_count > 0) used_count--;
        end
      end
      res.free_count = (used_count < lim) ? bpa_pkg::COUNT_W'(lim - used_count) : '0;
      expected_q.push_back(res);
    endfunction

    function void check_result(bpa_pkg::out_res_t got);
      bpa_pkg::out_res_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: status %0d page_address %0h free_count %0d",
               got.status, got.page_address, got.free_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.page_address !== want.page_address) begin
        $error("page_address: expected %0h, actual %0h", want.page_address, got.page_address);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  bpa_pkg::in_req_t            in_req;
  logic                        out_valid;
  bpa_pkg::out_res_t           out_res;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [bpa_pkg::COUNT_W-1:0] cfg_data;

  page_alloc_scoreboard sb;
  bit                   burst;
  int unsigned          cycle_count = 0;

  bitmap_page_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bitmap_page_allocator: mismatch");
      $finish;
    end
  end

  // Outputs only change at the rising edge, so the falling edge sees settled values
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_res);
  end

  function automatic bpa_pkg::in_req_t req_of(input logic mode,
                                              input logic [bpa_pkg::ADDR_W-1:0] addr);
    bpa_pkg::in_req_t req;
    req.mode    = mode;
    req.address = addr;
    return req;
  endfunction

  function automatic logic [bpa_pkg::ADDR_W-1:0] page_addr(input int unsigned page,
                                                           input logic [PAGE_SHIFT-1:0] offset);
    return (bpa_pkg::ADDR_W'(page) << PAGE_SHIFT) | bpa_pkg::ADDR_W'(offset);
  endfunction

  // Mostly allocations and frees of held pages; the rest double frees and noise
  function automatic bpa_pkg::in_req_t next_random_request();
    bpa_pkg::in_req_t        req;
    int unsigned             lim;
    int unsigned             r;
    int unsigned             idx;
    int unsigned             page;
    logic [PAGE_SHIFT-1:0]   offset;
    lim         = sb.active_limit();
    r           = $urandom_range(0, 99);
    offset      = ($urandom_range(0, 1) == 1) ? PAGE_SHIFT'($urandom) : '0;
    req.mode    = bpa_pkg::MODE_FREE;
    req.address = bpa_pkg::ADDR_W'({$urandom, $urandom});
    if (r < 48 || (r < 78 && sb.held_pages.size() == 0)) begin
      req.mode = bpa_pkg::MODE_ALLOC;
    end else if (r < 78) begin
      idx  = $urandom_range(0, sb.held_pages.size() - 1);
      page = sb.held_pages[idx];
      sb.held_pages.delete(idx);
      req.address = page_addr(page, offset);
    end else if (r < 86) begin
      page        = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
      req.address = page_addr(page, offset);
    end else if (r < 92) begin
      // keep the random address
    end else if (r < 96) begin
      req.address = '0;
    end else begin
      page        = (lim == 0) ? 0 : lim - $urandom_range(0, 1);
      req.address = page_addr(page, offset);
    end
    return req;
  endfunction

  // Enter and leave at a rising edge; leave at the edge of the transfer
  task automatic send_request(input bpa_pkg::in_req_t req);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic write_limit(input logic [bpa_pkg::COUNT_W-1:0] value);
    while (sb.expected_q.size() != 0) @(posedge clk);
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    cfg_valid    <= 1'b0;
    sb.limit_reg  = value;
  endtask

  initial begin
    logic [bpa_pkg::COUNT_W-1:0] phase_limits [10];
    phase_limits = '{17'd64, 17'd200, 17'd1, 17'd65, 17'd0,
                     17'd65536, 17'd130, 17'h1FFFF, 17'd300, 17'd2};
    sb = new();
    sb.reset_state();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    burst      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Null free, then page zero and its neighbors
    send_request(req_of(bpa_pkg::MODE_FREE, '0));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '1));
    send_request(req_of(bpa_pkg::MODE_ALLOC, 48'h5555_5555_5555));
    // Unaligned free, then the same page again
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0000_1ABC));
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0000_1000));
    // Out of range: widest address and the first page past the limit
    send_request(req_of(bpa_pkg::MODE_FREE, '1));
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_1000_0000));
    // Page zero freed through an offset-only address
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0000_0FFF));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    start <= 1'b0;

    write_limit(17'd0);
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0000_1000));
    start <= 1'b0;

    write_limit(17'd1);
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0000_0001));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    start <= 1'b0;

    // More pages in use than the limit allows: free count holds at zero
    write_limit(17'd2);
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0000_2000));
    start <= 1'b0;

    write_limit(17'h1FFFF);
    send_request(req_of(bpa_pkg::MODE_ALLOC, '0));
    send_request(req_of(bpa_pkg::MODE_FREE, 48'h0000_0FFF_F000));
    send_request(req_of(bpa_pkg::MODE_ALLOC, '1));
    start <= 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 8) phase_limits[ph] = bpa_pkg::COUNT_W'($urandom_range(3, 600));
      write_limit(phase_limits[ph]);
      burst = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        send_request(next_random_request());
        if ($urandom_range(0, 49) == 0) burst = !burst;
      end
      start <= 1'b0;
    end

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("bitmap_page_allocator: match");
    end else begin
      $display("bitmap_page_allocator: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_split.sv
sv/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
